[rtl/core/fpda_pkg.sv]
// Shared types and constants for the fixed-point decimal accumulator ALU.
// Used by fpda_ctrl, fpda_dp and the top level; no dependencies.
`default_nettype none

package fpda_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PROD_W    = 2 * DATA_W;
   // quotient bits retired per divider cycle
   localparam int unsigned DIV_RADIX = 2;
   localparam int unsigned DIV_STEPS = PROD_W / DIV_RADIX;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MULT   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, apply start clear
      logic mult;      // form magnitude product, set up divider
      logic div_step;  // one divider iteration
      logic finish;    // commit accumulator and response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic long_op;   // incoming request needs the multiply/divide path
      logic div_last;  // divider is on its final iteration
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/fpda_ctrl.sv]
// Controller state machine for the fixed-point decimal accumulator ALU.
// Depends on fpda_pkg; drives commands into fpda_dp and owns the handshakes.
`default_nettype none

module fpda_ctrl
   import fpda_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.long_op ? ST_MULT : ST_FINISH;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/fpda_dp.sv]
// Datapath for the fixed-point decimal accumulator ALU: accumulator, 32x32
// magnitude multiplier, radix-4 restoring divider and response register.
// Depends on fpda_pkg; sequenced by fpda_ctrl through cmd_type/sts_type.
`default_nettype none

module fpda_dp
   import fpda_pkg::*;
#(
   parameter int unsigned SCALE_FACTOR = 1000000
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire        [1:0]          req_mode,
   input  wire signed [DATA_W-1:0]   req_operand,
   input  wire                       req_start_req,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   output logic signed [DATA_W-1:0]  rsp_result,
   output logic                      rsp_div_by_zero
);

   localparam logic [DATA_W-1:0] SCALE_VAL = DATA_W'(SCALE_FACTOR);

   mode_type           mode_ff;
   logic [DATA_W-1:0]  opnd_ff;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0]  dvs_ff;
   logic               neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DATA_W-1:0]  result_ff;
   logic               dz_ff;

   logic [DATA_W-1:0]  acc_mag, opnd_mag, mul_b;
   logic [PROD_W-1:0]  prod;
   logic [DATA_W:0]    r1, r1n, r2, r2n;
   logic               ge1, ge2;
   logic [DATA_W-1:0]  quo_lo, res;
   logic               dz;

   // status for the request waiting at the input
   assign sts.long_op  = (mode_type'(req_mode) == MODE_MUL) ||
                         ((mode_type'(req_mode) == MODE_DIV) && (req_operand != '0));
   assign sts.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   // multiply on magnitudes; sign applied after the divide
   assign acc_mag  = acc_ff[DATA_W-1]  ? (~acc_ff + 1'b1)  : acc_ff;
   assign opnd_mag = opnd_ff[DATA_W-1] ? (~opnd_ff + 1'b1) : opnd_ff;
   assign mul_b    = (mode_ff == MODE_MUL) ? opnd_mag : SCALE_VAL;
   assign prod     = PROD_W'(acc_mag) * PROD_W'(mul_b);

   // two restoring steps per cycle; remainder always below the divisor
   always_comb begin
      r1  = {rem_ff, quo_ff[PROD_W-1]};
      ge1 = (r1 >= {1'b0, dvs_ff});
      r1n = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      r2  = {r1n[DATA_W-1:0], quo_ff[PROD_W-2]};
      ge2 = (r2 >= {1'b0, dvs_ff});
      r2n = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
      rem_in = r2n[DATA_W-1:0];
      quo_in = {quo_ff[PROD_W-3:0], ge1, ge2};
   end

   assign quo_lo = quo_ff[DATA_W-1:0];
   assign dz     = (mode_ff == MODE_DIV) && (opnd_ff == '0);

   always_comb begin
      case (mode_ff)
         MODE_ADD: res = acc_ff + opnd_ff;
         MODE_SUB: res = acc_ff - opnd_ff;
         default: begin
            if (dz) begin
               res = '0;
            end else begin
               res = neg_ff ? (~quo_lo + 1'b1) : quo_lo;
            end
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load && req_start_req) begin
         acc_in = '0;
      end else if (cmd.finish) begin
         acc_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         opnd_ff <= req_operand;
      end
      if (cmd.mult) begin
         quo_ff <= prod;
         rem_ff <= '0;
         dvs_ff <= (mode_ff == MODE_MUL) ? SCALE_VAL : opnd_mag;
         neg_ff <= acc_ff[DATA_W-1] ^ opnd_ff[DATA_W-1];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         result_ff <= res;
         dz_ff     <= dz;
      end
   end

   assign rsp_result      = result_ff;
   assign rsp_div_by_zero = dz_ff;

endmodule

`default_nettype wire

[rtl/core/fixed_point_decimal_accumulator_alu.sv]
// Channel  Handshake              Payload
// req      req_valid/req_stall    req_mode[1:0], req_operand[31:0], req_start_req
// rsp      rsp_valid/rsp_stall    rsp_result[31:0], rsp_div_by_zero
//
// One request at a time. Add, subtract and divide by zero go from accept straight to
// the finish state; multiply and divide pass through the multiply state and the
// divider, which retires 2 quotient bits per cycle over the 64-bit scaled product
// (32 iterations). Synchronous reset idles the controller and zeroes the accumulator.
// A held response keeps the next request in its finish state until rsp_stall
// drops; the next request is taken while a response waits.
//
// Top level: ties fpda_ctrl to fpda_dp. Depends on fpda_pkg.
`default_nettype none

module fixed_point_decimal_accumulator_alu
   import fpda_pkg::*;
#(
   parameter int unsigned SCALE_FACTOR = 1000000
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire        [1:0]          req_mode,
   input  wire signed [DATA_W-1:0]   req_operand,
   input  wire                       req_start_req,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_result,
   output logic                      rsp_div_by_zero
);

   cmd_type cmd;
   sts_type sts;

   fpda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fpda_dp #(
      .SCALE_FACTOR (SCALE_FACTOR)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_operand     (req_operand),
      .req_start_req   (req_start_req),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_result      (rsp_result),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

`ifndef SYNTH
   // a divide-by-zero response always carries a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_result == '0)
      else $error("div_by_zero response with nonzero result");

   // only one request in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   // commit never overwrites a held response
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid || !rsp_stall)
      else $error("response register overwritten while stalled");

   // at most one command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

[tb/fpda_result_checker.sv]
// Checker for the fixed-point decimal accumulator ALU: watches both channels,
// predicts each response from its own accumulator copy and compares fields.
// Depends on fpda_pkg for the operation codes and data width.
`default_nettype none

module fpda_result_checker
   import fpda_pkg::*;
#(
   parameter int unsigned SCALE_FACTOR = 1000000
)
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  wire        [1:0]         req_mode,
   input  wire signed [DATA_W-1:0]  req_operand,
   input  wire                      req_start_req,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  wire signed [DATA_W-1:0]  rsp_result,
   input  wire                      rsp_div_by_zero,
   output int                       error_count,
   output int                       open_requests,
   output int                       checked_count,
   output int                       zero_div_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     zero_div;
   } alu_outcome_type;

   localparam longint SCALE = longint'(SCALE_FACTOR);

   logic signed [DATA_W-1:0] running_acc = '0;
   alu_outcome_type          expected_q[$];
   int                       n_err = 0;
   int                       n_checked = 0;
   int                       n_zdiv = 0;

   // Multiply and divide go through 64 bits; both divisions truncate toward zero.
   function automatic alu_outcome_type apply_operation(input logic signed [DATA_W-1:0] acc,
                                                       input mode_type op,
                                                       input logic signed [DATA_W-1:0] opnd);
      longint          wide;
      alu_outcome_type o;
      wide       = 0;
      o.zero_div = 1'b0;
      o.value    = '0;
      case (op)
         MODE_ADD: o.value = acc + opnd;
         MODE_SUB: o.value = acc - opnd;
         MODE_MUL: begin
            wide    = (longint'(acc) * longint'(opnd)) / SCALE;
            o.value = wide[DATA_W-1:0];
         end
         MODE_DIV: begin
            if (opnd == 0) begin
               o.zero_div = 1'b1;
            end else begin
               wide    = (longint'(acc) * SCALE) / longint'(opnd);
               o.value = wide[DATA_W-1:0];
            end
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      alu_outcome_type want;
      logic signed [DATA_W-1:0] acc_in;
      if (reset) begin
         running_acc = '0;
         expected_q.delete();
      end else begin
         // a response always belongs to an earlier request, so retire first
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding: rsp_result %0d", rsp_result);
               n_err++;
            end else begin
               want = expected_q.pop_front();
               n_checked++;
               if (rsp_result !== want.value) begin
                  $error("rsp_result: expected %0d, got %0d", want.value, rsp_result);
                  n_err++;
               end
               if (rsp_div_by_zero !== want.zero_div) begin
                  $error("rsp_div_by_zero: expected %0b, got %0b", want.zero_div,
                         rsp_div_by_zero);
                  n_err++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            acc_in      = req_start_req ? '0 : running_acc;
            want        = apply_operation(acc_in, mode_type'(req_mode), req_operand);
            running_acc = want.value;
            if (want.zero_div) n_zdiv++;
            expected_q.push_back(want);
         end
      end
      error_count    <= n_err;
      open_requests  <= expected_q.size();
      checked_count  <= n_checked;
      zero_div_count <= n_zdiv;
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Top of the accumulator ALU testbench: clock, reset, request and response
// stimulus, watchdog and verdict. Depends on fpda_pkg, the block and fpda_result_checker.
`default_nettype none

module testbench;
   import fpda_pkg::*;

   localparam logic signed [DATA_W-1:0] OPND_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] OPND_MIN = 32'sh8000_0000;
   localparam int RANDOM_ITEMS = 850;
   localparam int QUIET_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic        [1:0]        req_mode;
   logic signed [DATA_W-1:0] req_operand;
   logic                     req_start_req;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_result;
   logic                     rsp_div_by_zero;

   int   error_count;
   int   open_requests;
   int   checked_count;
   int   zero_div_count;

   // knobs for the stimulus processes, set from the main sequence
   logic req_gaps_on  = 1'b1;
   logic rsp_gaps_on  = 1'b1;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;
   int   sent_count   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fixed_point_decimal_accumulator_alu DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_operand     (req_operand),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   fpda_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_operand     (req_operand),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_div_by_zero (rsp_div_by_zero),
      .error_count     (error_count),
      .open_requests   (open_requests),
      .checked_count   (checked_count),
      .zero_div_count  (zero_div_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: return $signed($urandom_range(0, 20_000_000)) - 10_000_000;
         3:       return ($signed($urandom_range(0, 200)) - 100) * 1_000_000;
         4: begin
            case ($urandom_range(0, 6))
               0: return 0;
               1: return 1;
               2: return -1;
               3: return OPND_MAX;
               4: return OPND_MIN;
               5: return 1_000_000;
               default: return -1_000_000;
            endcase
         end
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send_request(input mode_type op, input logic signed [DATA_W-1:0] opnd,
                               input logic clear_first);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= op;
      req_operand   <= opnd;
      req_start_req <= clear_first;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // response side: random stall bursts, or one long hold when asked
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else if (rsp_gaps_on) begin
            int gap;
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (8) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: %0d cycles with no request or response accepted", QUIET_LIMIT);
      $display("testbench: errors");
      $finish;
   end

   initial begin : main
      int       sel;
      mode_type op;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= MODE_ADD;
      req_operand   <= '0;
      req_start_req <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wrap on add/sub, product and quotient extremes, divide by zero
      send_request(MODE_ADD, OPND_MAX, 1'b1);
      send_request(MODE_ADD, 1, 1'b0);
      send_request(MODE_SUB, 1, 1'b0);
      send_request(MODE_SUB, OPND_MIN, 1'b1);
      send_request(MODE_ADD, 1_500_000, 1'b1);
      send_request(MODE_MUL, 2_000_000, 1'b0);
      send_request(MODE_MUL, OPND_MIN, 1'b0);
      send_request(MODE_ADD, 7_000_000, 1'b1);
      send_request(MODE_DIV, 2_000_000, 1'b0);
      send_request(MODE_DIV, 0, 1'b0);
      send_request(MODE_DIV, 5_000_000, 1'b1);
      send_request(MODE_ADD, -7_000_000, 1'b1);
      send_request(MODE_DIV, 3_000_000, 1'b0);
      send_request(MODE_MUL, 1, 1'b0);
      send_request(MODE_ADD, OPND_MIN, 1'b1);
      send_request(MODE_DIV, -1, 1'b0);
      send_request(MODE_ADD, OPND_MAX, 1'b1);
      send_request(MODE_MUL, OPND_MAX, 1'b0);
      send_request(MODE_ADD, OPND_MIN, 1'b1);
      send_request(MODE_MUL, OPND_MIN, 1'b0);
      send_request(MODE_DIV, 0, 1'b1);
      send_request(MODE_ADD, -1, 1'b1);
      send_request(MODE_MUL, 1, 1'b0);
      send_request(MODE_ADD, 1, 1'b1);
      send_request(MODE_DIV, OPND_MAX, 1'b0);

      // random: five phases with different idling, long hold in the first gap-free one
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % (RANDOM_ITEMS / 4) == 0) begin
            sel         = i / (RANDOM_ITEMS / 4);
            req_gaps_on = (sel == 0) || (sel == 2);
            rsp_gaps_on = (sel == 0) || (sel == 3);
            if (sel == 1) hold_request = 1'b1;
         end
         op = mode_type'($urandom_range(0, 3));
         send_request(op, pick_operand(), $urandom_range(0, 7) == 0);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (open_requests != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run summary: %0d requests sent, %0d responses checked, %0d divides by zero",
               sent_count, checked_count, zero_div_count);
      $display("long receiver hold %0s", hold_done ? "exercised" : "not reached");
      if (error_count == 0 && open_requests == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire
